>>> rtl/core/hspd_pkg.sv
// package for the humidity sensor pulse decoder
// widths, register indexes, reset values and shared beat types; no dependencies
`timescale 1ns / 1ps

package hspd_pkg;

    localparam int DUR_W          = 16;
    localparam int CFG_W          = 16;
    localparam int NUM_REGS       = 8;
    localparam int CFG_ADDR_W     = 3;
    localparam int FRAME_BYTES_DEF = 5;
    localparam int HUM_W          = 16;
    localparam int TEMP_W         = 15;

    localparam logic [DUR_W-1:0] RELEASE_MIN = 16'd30;

    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_MAX   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RESPONSE_MIN  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RESPONSE_MAX  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BIT_LOW_MIN   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BIT_LOW_MAX   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BIT_HIGH_MIN  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_BIT_HIGH_MAX  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_THRESHOLD = 3'd7;

    localparam logic [CFG_W-1:0] RST_RELEASE_MAX   = 16'd410;
    localparam logic [CFG_W-1:0] RST_RESPONSE_MIN  = 16'd140;
    localparam logic [CFG_W-1:0] RST_RESPONSE_MAX  = 16'd180;
    localparam logic [CFG_W-1:0] RST_BIT_LOW_MIN   = 16'd85;
    localparam logic [CFG_W-1:0] RST_BIT_LOW_MAX   = 16'd150;
    localparam logic [CFG_W-1:0] RST_BIT_HIGH_MIN  = 16'd34;
    localparam logic [CFG_W-1:0] RST_BIT_HIGH_MAX  = 16'd165;
    localparam logic [CFG_W-1:0] RST_ONE_THRESHOLD = 16'd96;

    typedef struct packed {
        logic [CFG_W-1:0] release_max;
        logic [CFG_W-1:0] response_min;
        logic [CFG_W-1:0] response_max;
        logic [CFG_W-1:0] bit_low_min;
        logic [CFG_W-1:0] bit_low_max;
        logic [CFG_W-1:0] bit_high_min;
        logic [CFG_W-1:0] bit_high_max;
        logic [CFG_W-1:0] one_threshold;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic             start;
        logic [DUR_W-1:0] duration;
    } in_beat_t;

    typedef struct packed {
        logic              ok;
        logic [HUM_W-1:0]  humidity;
        logic [TEMP_W-1:0] temperature;
        logic              negative;
    } result_t;

endpackage

>>> rtl/core/hspd_cfg_regs.sv
// configuration register file of the pulse decoder
// depends on hspd_pkg
`timescale 1ns / 1ps

module hspd_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [hspd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [hspd_pkg::CFG_W-1:0]     cfg_wdata,
    output hspd_pkg::cfg_t                 cfg
);
    import hspd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.release_max   <= RST_RELEASE_MAX;
            cfg_reg.response_min  <= RST_RESPONSE_MIN;
            cfg_reg.response_max  <= RST_RESPONSE_MAX;
            cfg_reg.bit_low_min   <= RST_BIT_LOW_MIN;
            cfg_reg.bit_low_max   <= RST_BIT_LOW_MAX;
            cfg_reg.bit_high_min  <= RST_BIT_HIGH_MIN;
            cfg_reg.bit_high_max  <= RST_BIT_HIGH_MAX;
            cfg_reg.one_threshold <= RST_ONE_THRESHOLD;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_RELEASE_MAX:   cfg_reg.release_max   <= cfg_wdata;
                REG_RESPONSE_MIN:  cfg_reg.response_min  <= cfg_wdata;
                REG_RESPONSE_MAX:  cfg_reg.response_max  <= cfg_wdata;
                REG_BIT_LOW_MIN:   cfg_reg.bit_low_min   <= cfg_wdata;
                REG_BIT_LOW_MAX:   cfg_reg.bit_low_max   <= cfg_wdata;
                REG_BIT_HIGH_MIN:  cfg_reg.bit_high_min  <= cfg_wdata;
                REG_BIT_HIGH_MAX:  cfg_reg.bit_high_max  <= cfg_wdata;
                REG_ONE_THRESHOLD: cfg_reg.one_threshold <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/hspd_in_stage.sv
// input register stage: holds one accepted duration beat for the decoder
// depends on hspd_pkg
`timescale 1ns / 1ps

module hspd_in_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [hspd_pkg::DUR_W-1:0] s_tdata,
    input  logic                      s_tuser,
    input  logic                      take,
    output hspd_pkg::in_beat_t        beat
);
    import hspd_pkg::*;

    logic             valid_reg;
    logic             start_reg;
    logic [DUR_W-1:0] duration_reg;
    logic             load;

    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            start_reg    <= s_tuser;
            duration_reg <= s_tdata;
        end
    end

    assign beat.valid    = valid_reg;
    assign beat.start    = start_reg;
    assign beat.duration = duration_reg;

endmodule

>>> rtl/core/hspd_frame_decode.sv
// frame decoder: window checks, bit shift, checksum and result register
// depends on hspd_pkg
`timescale 1ns / 1ps

module hspd_frame_decode #(
    parameter int FRAME_BYTES = hspd_pkg::FRAME_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  hspd_pkg::cfg_t     cfg,
    input  hspd_pkg::in_beat_t beat,
    output logic               take,
    output logic               res_valid,
    input  logic               res_ready,
    output hspd_pkg::result_t  res
);
    import hspd_pkg::*;

    localparam int TOTAL  = 3 + 16 * FRAME_BYTES;
    localparam int PH_W   = $clog2(TOTAL);
    localparam int BITS_W = 8 * FRAME_BYTES;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(TOTAL - 1);

    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [BITS_W-1:0] bits_reg, bits_next;
    logic              idle_reg, idle_next;
    logic              out_valid_reg;
    result_t           out_reg, out_next;
    logic              emit;

    logic [PH_W-1:0]   p_eff;
    logic [BITS_W-1:0] bits_eff, bits_new;
    logic              skip, win_ok, is_high, last, chk_ok;
    logic [DUR_W-1:0]  d;
    logic [7:0]        byte_w [8];
    logic [7:0]        sum;

    assign take = beat.valid && (!out_valid_reg || res_ready);
    assign d    = beat.duration;

    always_comb begin
        p_eff    = beat.start ? '0 : phase_reg;
        bits_eff = beat.start ? '0 : bits_reg;
        skip     = !beat.start && idle_reg;
        is_high  = 1'b0;
        if (p_eff == '0) begin
            win_ok = (d >= RELEASE_MIN) && (d <= cfg.release_max);
        end else if (p_eff < PH_W'(3)) begin
            win_ok = (d >= cfg.response_min) && (d <= cfg.response_max);
        end else if (p_eff[0]) begin
            win_ok = (d >= cfg.bit_low_min) && (d <= cfg.bit_low_max);
        end else begin
            win_ok  = (d >= cfg.bit_high_min) && (d <= cfg.bit_high_max);
            is_high = 1'b1;
        end
        bits_new = is_high ? {bits_eff[BITS_W-2:0], (d > cfg.one_threshold)} : bits_eff;
        last     = (p_eff == PH_LAST);
    end

    // byte k of the frame, MSB first; missing bytes read as zero
    genvar k;
    generate
        for (k = 0; k < 8; k++) begin : g_byte
            if (k < FRAME_BYTES) begin : g_have
                assign byte_w[k] = bits_new[8*(FRAME_BYTES-1-k) +: 8];
            end else begin : g_none
                assign byte_w[k] = 8'd0;
            end
        end
    endgenerate

    always_comb begin
        sum = 8'd0;
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            sum = sum + byte_w[i];
        end
        chk_ok = (sum == byte_w[FRAME_BYTES-1]);
    end

    always_comb begin
        phase_next = phase_reg;
        bits_next  = bits_reg;
        idle_next  = idle_reg;
        emit       = 1'b0;
        out_next   = '0;
        if (take && !skip) begin
            if (!win_ok) begin
                phase_next = p_eff;
                bits_next  = bits_eff;
                idle_next  = 1'b1;
                emit       = 1'b1;
            end else if (last) begin
                phase_next = '0;
                bits_next  = bits_new;
                idle_next  = 1'b1;
                emit       = 1'b1;
                if (chk_ok) begin
                    out_next.ok          = 1'b1;
                    out_next.humidity    = {byte_w[0], byte_w[1]};
                    out_next.temperature = {byte_w[2][6:0], byte_w[3]};
                    out_next.negative    = byte_w[2][7];
                end
            end else begin
                phase_next = p_eff + PH_W'(1);
                bits_next  = bits_new;
                idle_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            bits_reg      <= '0;
            idle_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            idle_reg  <= idle_next;
            if (take && emit) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && emit) begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.ok |->
            out_reg.humidity == '0 && out_reg.temperature == '0 && !out_reg.negative)
        else $error("error result with nonzero payload");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_LAST)
        else $error("phase index beyond frame length");

    a_idle_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        take && emit |=> idle_reg && out_valid_reg)
        else $error("decoder not idle after result");

    a_no_take_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !res_ready |-> !take)
        else $error("beat consumed while result register blocked");
`endif

endmodule

>>> rtl/core/humidity_sensor_pulse_decoder_top.sv
// the read's last beat passes the input register, then the result register raises m_tvalid
// throughput: one beat per cycle unless stalled, from the single compare and shift stage
// a result held in the output register with m_tready low stalls the decoder; one more beat
// waits in the input register, then s_tready drops until the result beat leaves
// reset: synchronous active-low aresetn restores register defaults and waits for a start beat
// depends on hspd_pkg, hspd_cfg_regs, hspd_in_stage, hspd_frame_decode
`timescale 1ns / 1ps

module humidity_sensor_pulse_decoder_top #(
    parameter int FRAME_BYTES = hspd_pkg::FRAME_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,    // duration
    input  logic                            s_tuser,    // frame_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,    // humidity, temperature, negative
    output logic                            m_tuser,    // ok
    input  logic                            cfg_we,
    input  logic [hspd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [hspd_pkg::CFG_W-1:0]      cfg_wdata
);
    import hspd_pkg::*;

    cfg_t     cfg;
    in_beat_t beat;
    result_t  res;
    logic     take;

    hspd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hspd_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .take     (take),
        .beat     (beat)
    );

    hspd_frame_decode #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .beat      (beat),
        .take      (take),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.negative, res.temperature, res.humidity};
    assign m_tuser = res.ok;

endmodule

>>> bench/testbench.sv
// self-checking bench for humidity_sensor_pulse_decoder_top: directed table, then random frames
// a decoder model or the row kind predicts each reading, checked by field; depends on hspd_pkg
`timescale 1ns / 1ps

module testbench;

    import hspd_pkg::*;

    localparam int FRAME_PULSES  = 3 + 16 * FRAME_BYTES_DEF;
    localparam int IDLE_PCT      = 18;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 950;
    localparam int MIN_READINGS  = 48;
    localparam int PHASE_ITEMS   = 140;
    localparam int DRAIN_LIMIT   = 20000;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_FAULT} row_kind_e;
    typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_PULSE, FRAME_CUT} frame_kind_e;

    typedef struct packed {
        logic             start;
        logic [DUR_W-1:0] dur;
        row_kind_e        kind;
    } pulse_beat_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;  // duration
    logic                  s_tuser   = 1'b0; // frame_start
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;         // humidity, temperature, negative
    logic                  m_tuser;         // ok
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    humidity_sensor_pulse_decoder_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    localparam pulse_beat_t DIRECTED_ROWS [27] = '{
        '{1'b0, 16'd100,  ROW_QUIET},   // idle after reset
        '{1'b1, 16'd29,   ROW_FAULT},
        '{1'b0, 16'd200,  ROW_QUIET},   // ignored after error
        '{1'b1, 16'd30,   ROW_QUIET},
        '{1'b0, 16'd139,  ROW_FAULT},
        '{1'b1, 16'd410,  ROW_QUIET},
        '{1'b0, 16'd140,  ROW_QUIET},
        '{1'b0, 16'd181,  ROW_FAULT},
        '{1'b1, 16'd411,  ROW_FAULT},
        '{1'b1, 16'd0,    ROW_FAULT},
        '{1'b1, 16'hFFFF, ROW_FAULT},
        '{1'b1, 16'd300,  ROW_QUIET},
        '{1'b0, 16'd180,  ROW_QUIET},
        '{1'b0, 16'd140,  ROW_QUIET},
        '{1'b0, 16'd85,   ROW_QUIET},
        '{1'b0, 16'd34,   ROW_QUIET},
        '{1'b0, 16'd150,  ROW_QUIET},
        '{1'b0, 16'd165,  ROW_QUIET},
        '{1'b0, 16'd84,   ROW_FAULT},
        '{1'b1, 16'd200,  ROW_QUIET},
        '{1'b0, 16'd160,  ROW_QUIET},
        '{1'b1, 16'd200,  ROW_QUIET},   // restart mid-frame
        '{1'b0, 16'd160,  ROW_QUIET},
        '{1'b0, 16'd160,  ROW_QUIET},
        '{1'b0, 16'd150,  ROW_QUIET},
        '{1'b0, 16'd166,  ROW_FAULT},
        '{1'b0, 16'd0,    ROW_QUIET}
    };

    // decoder model state
    logic [CFG_W-1:0]               window_regs [NUM_REGS];
    int                             pulse_count;
    logic [8*FRAME_BYTES_DEF-1:0]   shift_bits;
    logic                           awaiting_start;

    pulse_beat_t stim_q [$];
    result_t     pending_readings [$];
    pulse_beat_t cur_beat;
    int          cyc;
    int          errors        = 0;
    int          items_total   = 0;
    int          readings_seen = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic restore_defaults();
        window_regs[REG_RELEASE_MAX]   = RST_RELEASE_MAX;
        window_regs[REG_RESPONSE_MIN]  = RST_RESPONSE_MIN;
        window_regs[REG_RESPONSE_MAX]  = RST_RESPONSE_MAX;
        window_regs[REG_BIT_LOW_MIN]   = RST_BIT_LOW_MIN;
        window_regs[REG_BIT_LOW_MAX]   = RST_BIT_LOW_MAX;
        window_regs[REG_BIT_HIGH_MIN]  = RST_BIT_HIGH_MIN;
        window_regs[REG_BIT_HIGH_MAX]  = RST_BIT_HIGH_MAX;
        window_regs[REG_ONE_THRESHOLD] = RST_ONE_THRESHOLD;
    endtask

    function automatic logic out_of(logic [DUR_W-1:0] d, logic [CFG_W-1:0] lo,
                                    logic [CFG_W-1:0] hi);
        return d < lo || d > hi;
    endfunction

    task automatic decode_pulse(input logic start, input logic [DUR_W-1:0] d,
                                output logic has, output result_t reading);
        logic       bad;
        logic [7:0] sum;
        has     = 1'b0;
        reading = '0;
        bad     = 1'b0;
        if (start || !awaiting_start) begin
            if (start) begin
                awaiting_start = 1'b0;
                pulse_count    = 0;
                shift_bits     = '0;
            end
            if (pulse_count == 0) begin
                bad = out_of(d, RELEASE_MIN, window_regs[REG_RELEASE_MAX]);
            end else if (pulse_count < 3) begin
                bad = out_of(d, window_regs[REG_RESPONSE_MIN], window_regs[REG_RESPONSE_MAX]);
            end else if ((pulse_count - 3) % 2 == 0) begin
                bad = out_of(d, window_regs[REG_BIT_LOW_MIN], window_regs[REG_BIT_LOW_MAX]);
            end else begin
                bad = out_of(d, window_regs[REG_BIT_HIGH_MIN], window_regs[REG_BIT_HIGH_MAX]);
                if (!bad)
                    shift_bits = {shift_bits[8*FRAME_BYTES_DEF-2:0],
                                  d > window_regs[REG_ONE_THRESHOLD]};
            end
            if (bad) begin
                has            = 1'b1;
                awaiting_start = 1'b1;
            end else begin
                pulse_count++;
                if (pulse_count == FRAME_PULSES) begin
                    has            = 1'b1;
                    awaiting_start = 1'b1;
                    sum = shift_bits[39:32] + shift_bits[31:24] + shift_bits[23:16]
                        + shift_bits[15:8];
                    if (sum == shift_bits[7:0]) begin
                        reading.ok          = 1'b1;
                        reading.humidity    = shift_bits[39:24];
                        reading.temperature = shift_bits[22:8];
                        reading.negative    = shift_bits[23];
                    end
                end
            end
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        errors++;
        $display("%0t: reading %s mismatch, expected %0h actual %0h", $time, name, want, got);
    endtask

    always @(posedge aclk) begin : stream_proc
        logic    has;
        logic    calm;
        result_t reading;
        result_t want;
        if (!aresetn) begin
            s_tvalid       <= 1'b0;
            m_tready       <= 1'b0;
            cyc            = 0;
            pulse_count    = 0;
            shift_bits     = '0;
            awaiting_start = 1'b1;
            restore_defaults();
        end else begin
            cyc++;
            calm = cyc >= 600 && cyc < 1100;
            if (m_tvalid && m_tready) begin
                if (pending_readings.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected reading, expected none actual ok=%b data=%h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = pending_readings.pop_front();
                    if (m_tuser !== want.ok)
                        report_field("ok", want.ok, m_tuser);
                    if (m_tdata[15:0] !== want.humidity)
                        report_field("humidity", want.humidity, m_tdata[15:0]);
                    if (m_tdata[30:16] !== want.temperature)
                        report_field("temperature", want.temperature, m_tdata[30:16]);
                    if (m_tdata[31] !== want.negative)
                        report_field("negative", want.negative, m_tdata[31]);
                end
            end
            if (s_tvalid && s_tready) begin
                decode_pulse(cur_beat.start, cur_beat.dur, has, reading);
                if (cur_beat.kind == ROW_QUIET) begin
                    has = 1'b0;
                end else if (cur_beat.kind == ROW_FAULT) begin
                    has     = 1'b1;
                    reading = '0;
                end
                if (has) begin
                    pending_readings.push_back(reading);
                    readings_seen++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (stim_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    cur_beat = stim_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_beat.dur;
                    s_tuser  <= cur_beat.start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic int pick_in(int lo, int hi);
        if (lo <= hi)
            return $urandom_range(hi, lo);
        return $urandom_range(65535, 0);
    endfunction

    function automatic int outside_window(int lo, int hi);
        if (lo > hi)
            return $urandom_range(65535, 0);
        if (lo > 0 && (hi == 65535 || $urandom_range(1) == 1))
            return ($urandom_range(1) == 1) ? lo - 1 : $urandom_range(lo - 1, 0);
        if (hi < 65535)
            return ($urandom_range(1) == 1) ? hi + 1 : $urandom_range(65535, hi + 1);
        return $urandom_range(65535, 0);
    endfunction

    function automatic int bit_duration(logic bit_val, int lo, int hi);
        int thr;
        int a;
        int b;
        thr = window_regs[REG_ONE_THRESHOLD];
        a   = lo;
        b   = hi;
        if (bit_val) begin
            if (thr + 1 > a)
                a = thr + 1;
        end else if (thr < b) begin
            b = thr;
        end
        if (a > b)
            return pick_in(lo, hi);
        if ($urandom_range(7) == 0)
            return bit_val ? a : b;
        return pick_in(a, b);
    endfunction

    task automatic pulse_window(input int n, output int lo, output int hi);
        if (n == 0) begin
            lo = RELEASE_MIN;
            hi = window_regs[REG_RELEASE_MAX];
        end else if (n < 3) begin
            lo = window_regs[REG_RESPONSE_MIN];
            hi = window_regs[REG_RESPONSE_MAX];
        end else if (n % 2 == 1) begin
            lo = window_regs[REG_BIT_LOW_MIN];
            hi = window_regs[REG_BIT_LOW_MAX];
        end else begin
            lo = window_regs[REG_BIT_HIGH_MIN];
            hi = window_regs[REG_BIT_HIGH_MAX];
        end
    endtask

    task automatic queue_frame(input frame_kind_e kind);
        logic [7:0]       bytes [FRAME_BYTES_DEF];
        logic [7:0]       sum;
        logic             bit_val;
        logic [DUR_W-1:0] d;
        int               limit;
        int               lo;
        int               hi;
        int               n;
        int               bit_pos;
        sum = '0;
        for (n = 0; n < FRAME_BYTES_DEF - 1; n++) begin
            bytes[n] = 8'($urandom);
            sum      = sum + bytes[n];
        end
        bytes[FRAME_BYTES_DEF-1] = (kind == FRAME_BAD_SUM) ? sum ^ 8'($urandom_range(255, 1))
                                                           : sum;
        case (kind)
            FRAME_BAD_PULSE: limit = $urandom_range(FRAME_PULSES, 1);
            FRAME_CUT:       limit = $urandom_range(FRAME_PULSES - 1, 1);
            default:         limit = FRAME_PULSES;
        endcase
        for (n = 0; n < limit; n++) begin
            pulse_window(n, lo, hi);
            if (kind == FRAME_BAD_PULSE && n == limit - 1) begin
                d = DUR_W'(outside_window(lo, hi));
            end else if (n >= 4 && n % 2 == 0) begin
                bit_pos = (n - 4) / 2;
                bit_val = bytes[bit_pos / 8][7 - bit_pos % 8];
                d       = DUR_W'(bit_duration(bit_val, lo, hi));
            end else begin
                d = DUR_W'(pick_in(lo, hi));
            end
            stim_q.push_back('{start: (n == 0), dur: d, kind: ROW_PREDICT});
            items_total++;
        end
        // stray durations while waiting for a start
        if (kind != FRAME_CUT && $urandom_range(3) == 0)
            repeat ($urandom_range(3, 1))
                stim_q.push_back('{start: 1'b0, dur: DUR_W'($urandom), kind: ROW_PREDICT});
    endtask

    task automatic apply_setting(input int sel);
        int i;
        case (sel % 7)
            0: restore_defaults();
            1: begin
                restore_defaults();
                for (i = 0; i < NUM_REGS; i++)
                    window_regs[i] = window_regs[i] + CFG_W'($urandom_range(20)) - CFG_W'(10);
            end
            2, 3: begin
                window_regs[REG_RELEASE_MAX]   = '1;
                window_regs[REG_RESPONSE_MIN]  = '0;
                window_regs[REG_RESPONSE_MAX]  = '1;
                window_regs[REG_BIT_LOW_MIN]   = '0;
                window_regs[REG_BIT_LOW_MAX]   = '1;
                window_regs[REG_BIT_HIGH_MIN]  = '0;
                window_regs[REG_BIT_HIGH_MAX]  = '1;
                window_regs[REG_ONE_THRESHOLD] = (sel % 7 == 2) ? '1 : '0;
            end
            4: for (i = 0; i < NUM_REGS; i++) window_regs[i] = '0;
            5: for (i = 0; i < NUM_REGS; i++) window_regs[i] = CFG_W'($urandom);
            default: begin
                restore_defaults();
                window_regs[REG_BIT_HIGH_MIN] = RST_BIT_HIGH_MAX + 1'b1;
            end
        endcase
        for (i = 0; i < NUM_REGS; i++) begin
            @(posedge aclk);
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_ADDR_W'(i);
            cfg_wdata <= window_regs[i];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (stim_q.size() != 0 || s_tvalid || pending_readings.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        #(12 * 500000);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : main_seq
        int          sel;
        int          phase_start;
        int          roll;
        int          guard;
        frame_kind_e kind;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (DIRECTED_ROWS[i])
            stim_q.push_back(DIRECTED_ROWS[i]);
        sel = 0;
        forever begin
            settle();
            if (items_total >= RANDOM_ITEMS && readings_seen >= MIN_READINGS)
                break;
            apply_setting(sel);
            sel++;
            phase_start = items_total;
            while (items_total - phase_start < PHASE_ITEMS) begin
                roll = $urandom_range(99);
                if (roll < 45)
                    kind = FRAME_GOOD;
                else if (roll < 60)
                    kind = FRAME_BAD_SUM;
                else if (roll < 85)
                    kind = FRAME_BAD_PULSE;
                else
                    kind = FRAME_CUT;
                queue_frame(kind);
            end
        end
        guard = 0;
        while ((stim_q.size() != 0 || s_tvalid || pending_readings.size() != 0)
               && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (pending_readings.size() != 0 || stim_q.size() != 0) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            repeat (SETTLE_CYCLES) @(posedge aclk);
            if (errors == 0)
                $display("TB_OK");
            else
                $display("TB_ERROR");
            $finish;
        end
    end

endmodule

>>> sim.f
rtl/core/hspd_pkg.sv
rtl/core/hspd_cfg_regs.sv
rtl/core/hspd_in_stage.sv
rtl/core/hspd_frame_decode.sv
rtl/core/humidity_sensor_pulse_decoder_top.sv
bench/testbench.sv
